// File: rtl/gewc_pkg.sv
// Shared types and constants for the grid exit walk counter.
package gewc_pkg;

	localparam int unsigned CNT_W = 30;
	localparam logic [CNT_W-1:0] WALK_MOD = 30'd1000000007;

	typedef struct packed {
		logic [6:0] grid_rows;
		logic [6:0] grid_cols;
		logic [6:0] move_budget;
		logic [5:0] start_row;
		logic [5:0] start_col;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] path_count;
		logic             bad_request;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_LAYER,
		ST_DRAIN,
		ST_FETCH,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		DIR_UP,
		DIR_RIGHT,
		DIR_DOWN,
		DIR_LEFT
	} dir_t;

	typedef struct packed {
		logic load;
		logic add;
	} acc_ctl_t;

endpackage

// File: rtl/gewc_mod_acc.sv
// Modular accumulator: the shared add-and-reduce unit for neighbor sums.
module gewc_mod_acc (
	input  logic                          clk,
	input  gewc_pkg::acc_ctl_t            ctl,
	input  logic [gewc_pkg::CNT_W-1:0]    operand,
	output logic [gewc_pkg::CNT_W-1:0]    acc
);

	logic [gewc_pkg::CNT_W-1:0] acc_q;
	logic [gewc_pkg::CNT_W-1:0] base;
	logic [gewc_pkg::CNT_W:0]   sum;
	logic [gewc_pkg::CNT_W:0]   red;

	always_comb begin
		base = ctl.load ? '0 : acc_q;
		sum  = {1'b0, base} + {1'b0, operand};
		red  = (sum >= {1'b0, gewc_pkg::WALK_MOD}) ? sum - {1'b0, gewc_pkg::WALK_MOD} : sum;
	end

	always_ff @(posedge clk) begin
		if (ctl.add) begin
			acc_q <= red[gewc_pkg::CNT_W-1:0];
		end
	end

	assign acc = acc_q;

endmodule

// File: rtl/grid_exit_walk_counter_unit.sv
// Top level: counts grid-exiting walks with a layer-by-layer DP over two rolling layers.
// Usage:
//   Command channel: req is taken at a rising edge where start is high and busy is low.
//   Result channel: done is high for exactly one cycle while rsp holds the result;
//   the receiver cannot stall, so each result must be captured on that cycle.
//   A rejected request (empty or oversized grid, budget too large, start off the
//   grid) returns path_count 0 with bad_request set in the cycle after acceptance,
//   and busy never rises for it.
//   A valid request keeps busy high while the sequencer first clears layer 0,
//   cell by cell; then each layer visits every cell and reads its four neighbors,
//   one read per cycle on the single read port of the layer memory, plus a drain
//   after each layer until the pipeline is empty; then it fetches the start cell
//   and loads the result. done pulses in the cycle that busy falls, and a new
//   request may be accepted in that same cycle.
//   The layer memory is not cleared at reset; every entry whose value is used is
//   written before it is read within a request. Reset returns the sequencer to
//   idle with busy low.
module grid_exit_walk_counter_unit #(
	parameter int MAX_ROWS  = 64,
	parameter int MAX_COLS  = 64,
	parameter int MAX_MOVES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  gewc_pkg::req_t       req,
	output logic                 done,
	output gewc_pkg::rsp_t       rsp
);

	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int KW    = $clog2(MAX_MOVES + 1);
	localparam int AW    = 1 + RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam logic [31:0] ROWS_LIM  = 32'(MAX_ROWS);
	localparam logic [31:0] COLS_LIM  = 32'(MAX_COLS);
	localparam logic [31:0] MOVES_LIM = 32'(MAX_MOVES);

	gewc_pkg::state_t state_q, state_d;

	logic [6:0]    rows_q, cols_q;
	logic [RW-1:0] srow_q, r_q, last_r, nr;
	logic [CW-1:0] scol_q, c_q, last_c, nc;
	logic [KW-1:0] k_q;
	logic          cur_q;
	gewc_pkg::dir_t d_q;

	logic          accept, req_bad, row_end, col_end, grid_end, issue, nb_out;
	logic          rd_en, wr_en;
	logic [AW-1:0] rd_addr, wr_addr;
	logic [gewc_pkg::CNT_W-1:0] wr_data, rd_q, operand, acc;

	logic [gewc_pkg::CNT_W-1:0] mem [DEPTH];

	logic          vld_s1, first_s1, last_s1, out_s1;
	logic [AW-1:0] waddr_s1;
	logic          wr_s2;
	logic [AW-1:0] waddr_s2;

	logic           done_q;
	gewc_pkg::rsp_t rsp_q;
	gewc_pkg::acc_ctl_t acc_ctl;

	always_comb begin
		req_bad = (req.grid_rows == 7'd0) || (req.grid_cols == 7'd0) ||
			({25'd0, req.grid_rows} > ROWS_LIM) || ({25'd0, req.grid_cols} > COLS_LIM) ||
			({25'd0, req.move_budget} > MOVES_LIM) ||
			({1'b0, req.start_row} >= req.grid_rows) ||
			({1'b0, req.start_col} >= req.grid_cols);
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			gewc_pkg::ST_IDLE: begin
				if (start && !req_bad) state_d = gewc_pkg::ST_INIT;
			end
			gewc_pkg::ST_INIT: begin
				if (grid_end) state_d = (k_q == '0) ? gewc_pkg::ST_FETCH : gewc_pkg::ST_LAYER;
			end
			gewc_pkg::ST_LAYER: begin
				if (d_q == gewc_pkg::DIR_LEFT && grid_end) state_d = gewc_pkg::ST_DRAIN;
			end
			gewc_pkg::ST_DRAIN: begin
				if (!vld_s1 && !wr_s2) begin
					state_d = (k_q == '0) ? gewc_pkg::ST_FETCH : gewc_pkg::ST_LAYER;
				end
			end
			gewc_pkg::ST_FETCH:  state_d = gewc_pkg::ST_RESULT;
			gewc_pkg::ST_RESULT: state_d = gewc_pkg::ST_IDLE;
			default:             state_d = gewc_pkg::ST_IDLE;
		endcase
	end

	// outputs and datapath control
	always_comb begin
		busy     = (state_q != gewc_pkg::ST_IDLE);
		accept   = start && (state_q == gewc_pkg::ST_IDLE);
		last_r   = RW'(rows_q - 7'd1);
		last_c   = CW'(cols_q - 7'd1);
		row_end  = (r_q == last_r);
		col_end  = (c_q == last_c);
		grid_end = row_end && col_end;
		issue    = (state_q == gewc_pkg::ST_LAYER);

		nr     = r_q;
		nc     = c_q;
		nb_out = 1'b0;
		case (d_q)
			gewc_pkg::DIR_UP: begin
				nr     = r_q - RW'(1);
				nb_out = (r_q == '0);
			end
			gewc_pkg::DIR_RIGHT: begin
				nc     = c_q + CW'(1);
				nb_out = col_end;
			end
			gewc_pkg::DIR_DOWN: begin
				nr     = r_q + RW'(1);
				nb_out = row_end;
			end
			gewc_pkg::DIR_LEFT: begin
				nc     = c_q - CW'(1);
				nb_out = (c_q == '0);
			end
			default: nb_out = 1'b0;
		endcase

		rd_en   = issue || (state_q == gewc_pkg::ST_FETCH);
		rd_addr = issue ? {cur_q, nr, nc} : {cur_q, srow_q, scol_q};

		wr_en   = wr_s2 || (state_q == gewc_pkg::ST_INIT);
		wr_addr = wr_s2 ? waddr_s2 : {cur_q, r_q, c_q};
		wr_data = wr_s2 ? acc : '0;

		acc_ctl.load = vld_s1 && first_s1;
		acc_ctl.add  = vld_s1;
		operand      = out_s1 ? gewc_pkg::CNT_W'(1) : rd_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	gewc_mod_acc u_acc (
		.clk     (clk),
		.ctl     (acc_ctl),
		.operand (operand),
		.acc     (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gewc_pkg::ST_IDLE;
			r_q     <= '0;
			c_q     <= '0;
			d_q     <= gewc_pkg::DIR_UP;
			k_q     <= '0;
			cur_q   <= 1'b0;
			vld_s1  <= 1'b0;
			wr_s2   <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			wr_s2   <= vld_s1 && last_s1;
			done_q  <= (accept && req_bad) || (state_q == gewc_pkg::ST_RESULT);

			if (accept) begin
				r_q   <= '0;
				c_q   <= '0;
				d_q   <= gewc_pkg::DIR_UP;
				cur_q <= 1'b0;
				k_q   <= KW'(req.move_budget);
			end else if (state_q == gewc_pkg::ST_INIT) begin
				c_q <= col_end ? '0 : c_q + CW'(1);
				if (col_end) r_q <= row_end ? '0 : r_q + RW'(1);
			end else if (issue) begin
				d_q <= gewc_pkg::dir_t'(d_q + 2'd1);
				if (d_q == gewc_pkg::DIR_LEFT) begin
					c_q <= col_end ? '0 : c_q + CW'(1);
					if (col_end) r_q <= row_end ? '0 : r_q + RW'(1);
					if (grid_end) begin
						cur_q <= ~cur_q;
						k_q   <= k_q - KW'(1);
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rows_q <= req.grid_rows;
			cols_q <= req.grid_cols;
			srow_q <= RW'(req.start_row);
			scol_q <= CW'(req.start_col);
		end
		first_s1 <= (d_q == gewc_pkg::DIR_UP);
		last_s1  <= (d_q == gewc_pkg::DIR_LEFT);
		out_s1   <= nb_out;
		waddr_s1 <= {~cur_q, r_q, c_q};
		waddr_s2 <= waddr_s1;
		if (accept) begin
			rsp_q.path_count  <= '0;
			rsp_q.bad_request <= 1'b1;
		end else if (state_q == gewc_pkg::ST_RESULT) begin
			rsp_q.path_count  <= rd_q;
			rsp_q.bad_request <= 1'b0;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// File: rtl/gewc_checker.sv
// Port-level checker for the grid exit walk counter, bound to the top level.
module gewc_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input gewc_pkg::rsp_t rsp
);

	a_count_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (rsp.path_count < gewc_pkg::WALK_MOD))
		else $error("path_count not reduced");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.bad_request) |-> (rsp.path_count == '0))
		else $error("rejected transaction with nonzero count");

	a_accept_response: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction neither running nor answered");

	a_good_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.bad_request) |-> $fell(busy))
		else $error("valid result outside end of run");

endmodule

bind grid_exit_walk_counter_unit gewc_checker u_gewc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

// File: tb/grid_exit_walk_counter_unit_tb.sv
// Self-checking testbench for the grid exit walk counter: directed and random requests.
module grid_exit_walk_counter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS_LIM    = 64;
	localparam int COLS_LIM    = 64;
	localparam int MOVES_LIM   = 64;
	localparam int STALL_LIMIT = 400000;
	localparam int WORK_CAP    = 4096;
	localparam int RAND_ITEMS  = 100;

	class exit_walk_checker;
		gewc_pkg::rsp_t             expected_counts[$];
		int                         mismatches;
		int                         valid_seen;
		int                         rejected_seen;
		logic [gewc_pkg::CNT_W-1:0] layer[2][ROWS_LIM][COLS_LIM];

		function gewc_pkg::rsp_t count_exit_walks(gewc_pkg::req_t r);
			gewc_pkg::rsp_t  res;
			int              rows;
			int              cols;
			int              cur;
			longint unsigned sum;
			res.path_count  = '0;
			res.bad_request = 1'b1;
			if (r.grid_rows == 0 || r.grid_cols == 0 || r.grid_rows > ROWS_LIM ||
				r.grid_cols > COLS_LIM || r.move_budget > MOVES_LIM ||
				r.start_row >= r.grid_rows || r.start_col >= r.grid_cols)
				return res;
			rows = r.grid_rows;
			cols = r.grid_cols;
			for (int i = 0; i < rows; i++)
				for (int j = 0; j < cols; j++)
					layer[0][i][j] = '0;
			cur = 0;
			for (int k = 1; k <= r.move_budget; k++) begin
				for (int i = 0; i < rows; i++) begin
					for (int j = 0; j < cols; j++) begin
						// off-grid neighbors are worth one walk
						sum = (i == 0) ? 64'd1 : 64'(layer[cur][i-1][j]);
						sum += (j == cols - 1) ? 64'd1 : 64'(layer[cur][i][j+1]);
						sum += (i == rows - 1) ? 64'd1 : 64'(layer[cur][i+1][j]);
						sum += (j == 0) ? 64'd1 : 64'(layer[cur][i][j-1]);
						layer[cur ^ 1][i][j] =
							gewc_pkg::CNT_W'(sum % 64'(gewc_pkg::WALK_MOD));
					end
				end
				cur ^= 1;
			end
			res.path_count  = layer[cur][r.start_row][r.start_col];
			res.bad_request = 1'b0;
			return res;
		endfunction

		function void note_request(gewc_pkg::req_t r);
			gewc_pkg::rsp_t want;
			want = count_exit_walks(r);
			expected_counts.push_back(want);
			if (want.bad_request)
				rejected_seen++;
			else
				valid_seen++;
		endfunction

		task report_mismatch(string what, longint unsigned want, longint unsigned got);
			$display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
			mismatches++;
		endtask

		task check_result(gewc_pkg::rsp_t got);
			gewc_pkg::rsp_t want;
			if (expected_counts.size() == 0) begin
				report_mismatch("result with no pending transaction", 0, got.path_count);
				return;
			end
			want = expected_counts.pop_front();
			if (got.path_count !== want.path_count)
				report_mismatch("path_count", want.path_count, got.path_count);
			if (got.bad_request !== want.bad_request)
				report_mismatch("bad_request", want.bad_request, got.bad_request);
		endtask
	endclass

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	logic           done;
	gewc_pkg::req_t req;
	gewc_pkg::rsp_t rsp;
	bit             quiet_stretch;
	int             stall_cycles = 0;

	exit_walk_checker walk_sb = new();

	grid_exit_walk_counter_unit #(
		.MAX_ROWS (ROWS_LIM),
		.MAX_COLS (COLS_LIM),
		.MAX_MOVES(MOVES_LIM)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.req   (req),
		.done  (done),
		.rsp   (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				walk_sb.check_result(rsp);
			if (start && !busy)
				walk_sb.note_request(req);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || done || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function gewc_pkg::req_t make_req(int rows, int cols, int budget, int srow, int scol);
		gewc_pkg::req_t item;
		item.grid_rows   = 7'(rows);
		item.grid_cols   = 7'(cols);
		item.move_budget = 7'(budget);
		item.start_row   = 6'(srow);
		item.start_col   = 6'(scol);
		return item;
	endfunction

	function gewc_pkg::req_t rand_request();
		gewc_pkg::req_t item;
		int             sel;
		int             rows;
		int             cols;
		int             budget;
		sel = $urandom_range(99);
		if (sel < 70) begin
			rows   = $urandom_range(1, 8);
			cols   = $urandom_range(1, 8);
			budget = $urandom_range(0, MOVES_LIM);
			item = make_req(rows, cols, budget, $urandom_range(0, rows - 1),
				$urandom_range(0, cols - 1));
		end else if (sel < 80) begin
			rows   = $urandom_range(1, ROWS_LIM);
			cols   = $urandom_range(1, COLS_LIM);
			budget = WORK_CAP / (rows * cols);
			if (budget > MOVES_LIM)
				budget = MOVES_LIM;
			item = make_req(rows, cols, $urandom_range(0, budget),
				$urandom_range(0, rows - 1), $urandom_range(0, cols - 1));
		end else if (sel < 90) begin
			// start just off the grid
			rows = $urandom_range(1, 63);
			cols = $urandom_range(1, 63);
			if ($urandom_range(1))
				item = make_req(rows, cols, $urandom_range(0, 127), rows,
					$urandom_range(0, 63));
			else
				item = make_req(rows, cols, $urandom_range(0, 127),
					$urandom_range(0, 63), cols);
		end else begin
			item = gewc_pkg::req_t'({1'($urandom), $urandom});
			if (item.grid_rows != 0 && item.grid_cols != 0 &&
				item.grid_rows <= ROWS_LIM && item.grid_cols <= COLS_LIM &&
				item.move_budget <= MOVES_LIM && item.start_row < item.grid_rows &&
				item.start_col < item.grid_cols &&
				int'(item.grid_rows) * int'(item.grid_cols) * int'(item.move_budget) >
				WORK_CAP)
				item.move_budget = 7'($urandom_range(MOVES_LIM + 1, 127));
		end
		return item;
	endfunction

	task send_request(gewc_pkg::req_t item);
		int gap;
		if (!quiet_stretch && $urandom_range(99) < 19) begin
			gap = $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				start <= 1'b0;
			end
		end
		@(negedge clk);
		start <= 1'b1;
		req   <= item;
		do
			@(posedge clk);
		while (busy);
	endtask

	initial begin
		gewc_pkg::req_t directed[$];
		arst_n        = 1'b0;
		start         = 1'b0;
		req           = '0;
		quiet_stretch = 1'b0;

		directed.push_back(make_req(1, 1, 0, 0, 0));
		directed.push_back(make_req(1, 1, 1, 0, 0));
		directed.push_back(make_req(1, 1, 64, 0, 0));
		directed.push_back(make_req(0, 5, 3, 0, 0));
		directed.push_back(make_req(5, 0, 3, 0, 0));
		directed.push_back(make_req(0, 0, 0, 0, 0));
		directed.push_back(make_req(65, 4, 3, 1, 1));
		directed.push_back(make_req(127, 127, 127, 63, 63));
		directed.push_back(make_req(4, 65, 3, 1, 1));
		directed.push_back(make_req(3, 3, 65, 1, 1));
		directed.push_back(make_req(3, 3, 127, 1, 1));
		directed.push_back(make_req(3, 3, 5, 3, 1));
		directed.push_back(make_req(3, 3, 5, 1, 3));
		directed.push_back(make_req(2, 2, 2, 63, 63));
		directed.push_back(make_req(2, 2, 0, 1, 1));
		directed.push_back(make_req(2, 2, 2, 1, 0));
		directed.push_back(make_req(3, 3, 64, 1, 1));
		directed.push_back(make_req(64, 1, 64, 63, 0));
		directed.push_back(make_req(1, 64, 64, 0, 63));
		directed.push_back(make_req(64, 64, 0, 0, 0));
		directed.push_back(make_req(64, 64, 1, 0, 0));
		directed.push_back(make_req(64, 64, 2, 32, 31));
		directed.push_back(make_req(64, 64, 4, 63, 63));
		directed.push_back(make_req(8, 8, 64, 4, 3));

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_request(directed[i]);
		for (int i = 0; i < RAND_ITEMS; i++) begin
			quiet_stretch = (i >= 40 && i < 60);
			send_request(rand_request());
		end
		@(negedge clk);
		start <= 1'b0;

		while (walk_sb.expected_counts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("ran %0d requests: %0d counted walks, %0d rejected",
			walk_sb.valid_seen + walk_sb.rejected_seen, walk_sb.valid_seen,
			walk_sb.rejected_seen);
		$display("grids 1x1 to 64x64, budgets 0 to 64, bad grids/budgets/starts, random gaps");
		if (walk_sb.mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
